/* hdl/uvq_pkg.sv */
// ----------------------------------------------------------------------------
// uvq_pkg
// Shared types and status codes for the unique value ordered queue.
// ----------------------------------------------------------------------------
package uvq_pkg;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DUP      = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // Operation codes carried on req_mode
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;    // latch the request transaction, restart the scan
      logic srch_rd;    // read entry at scan pointer
      logic set_found;  // record match at scan pointer
      logic ptr_inc;    // advance scan pointer
      logic shft_rd;    // read entry above scan pointer
      logic shft_wr;    // write shifted entry at scan pointer
      logic finish;     // commit count and load result register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic mode;       // latched operation
      logic match;      // read data equals latched value
      logic at_end;     // scan pointer equals entry count
      logic next_end;   // scan pointer + 1 equals entry count
      logic out_free;   // result register can take a new transaction
   } sts_type;

endpackage

/* hdl/unique_value_ordered_queue.sv */
// ----------------------------------------------------------------------------
// unique_value_ordered_queue
// Ordered set of distinct 32-bit values in arrival order, with insert at the
// newest end and delete by value anywhere, gap closed to keep order.
//
//   Channel   Ports                                  Direction
//   request   req_valid/req_ready, req_mode,         in
//             req_value
//   response  rsp_valid/rsp_ready, rsp_status,       out
//             rsp_count, rsp_position
//
// One transaction at a time. The entry memory has one read and one write port,
// so each entry compared passes through a read state and a compare state, and
// each newer entry moved down on a delete through a read and a write state.
// Reset empties the store at once (count to zero).
// A finished result waits in the output register while the next request is
// taken; the sequencer stalls only at commit if that register is still full.
// ----------------------------------------------------------------------------
module unique_value_ordered_queue #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic [3:0]         rsp_position
);
   import uvq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   uvq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   uvq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_position (rsp_position)
   );

endmodule

/* hdl/uvq_dpath.sv */
// ----------------------------------------------------------------------------
// uvq_dpath
// Entry memory, scan pointer, entry count and result register.
// ----------------------------------------------------------------------------
module uvq_dpath #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_mode,
   input  logic signed [31:0] req_value,
   input  uvq_pkg::cmd_type   cmd,
   output uvq_pkg::sts_type   sts,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic [3:0]         rsp_position
);
   import uvq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [31:0]    mem_ff [CAPACITY];
   logic [31:0]    rd_data_ff;
   logic [31:0]    value_ff;
   logic           mode_ff;
   logic           found_ff;
   logic [CW-1:0]  ptr_ff,   ptr_in;
   logic [CW-1:0]  pos_ff;
   logic [CW-1:0]  count_ff, count_in;
   logic           valid_ff, valid_in;
   logic [1:0]     status_ff;
   logic [4:0]     rcount_ff;
   logic [3:0]     rpos_ff;

   logic [CW-1:0]  ptr_plus1;
   logic           full;
   logic           ins_ok;
   logic           del_ok;
   logic [1:0]     fin_status;
   logic [CW-1:0]  fin_pos;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [31:0]    wr_data;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [CW+4:0]  count_wide;
   logic [CW+3:0]  pos_wide;

   assign ptr_plus1 = ptr_ff + 1'b1;
   assign full      = (count_ff == CAP_C);
   assign ins_ok    = (mode_ff == MODE_INSERT) && !found_ff && !full;
   assign del_ok    = (mode_ff == MODE_DELETE) && found_ff;

   // Outcome of the finished scan
   always_comb begin
      if (mode_ff == MODE_INSERT) begin
         if (found_ff)  fin_status = ST_DUP;
         else if (full) fin_status = ST_FULL;
         else           fin_status = ST_OK;
      end else begin
         fin_status = found_ff ? ST_OK : ST_NOTFOUND;
      end
   end

   always_comb begin
      if (ins_ok)      fin_pos = count_ff;
      else if (del_ok) fin_pos = pos_ff;
      else             fin_pos = '0;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.finish && ins_ok)      count_in = count_ff + 1'b1;
      else if (cmd.finish && del_ok) count_in = count_ff - 1'b1;
   end

   // Result fields are truncated to the port widths
   assign count_wide = {5'd0, count_in};
   assign pos_wide   = {4'd0, fin_pos};

   // Memory port control
   assign wr_en   = cmd.shft_wr || (cmd.finish && ins_ok);
   assign wr_addr = cmd.shft_wr ? ptr_ff[AW-1:0] : count_ff[AW-1:0];
   assign wr_data = cmd.shft_wr ? rd_data_ff : value_ff;
   assign rd_en   = cmd.srch_rd || cmd.shft_rd;
   assign rd_addr = cmd.shft_rd ? ptr_plus1[AW-1:0] : ptr_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   // Scan pointer
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.capture)      ptr_in = '0;
      else if (cmd.ptr_inc) ptr_in = ptr_plus1;
   end

   // Result handshake
   always_comb begin
      valid_in = valid_ff;
      if (cmd.finish)     valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
         valid_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         valid_ff <= valid_in;
         if (cmd.capture)        found_ff <= 1'b0;
         else if (cmd.set_found) found_ff <= 1'b1;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
      end
      if (cmd.set_found) pos_ff <= ptr_ff;
      if (cmd.finish) begin
         status_ff <= fin_status;
         rcount_ff <= count_wide[4:0];
         rpos_ff   <= pos_wide[3:0];
      end
   end

   assign sts.mode     = mode_ff;
   assign sts.match    = (rd_data_ff == value_ff);
   assign sts.at_end   = (ptr_ff == count_ff);
   assign sts.next_end = (ptr_plus1 == count_ff);
   assign sts.out_free = !valid_ff || rsp_ready;

   assign rsp_valid    = valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_count    = rcount_ff;
   assign rsp_position = rpos_ff;

`ifndef NO_ASSERTIONS
   // Store never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("entry count above capacity");

   // Scan pointer never runs past the stored entries
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff)
      else $error("scan pointer past entry count");

   // A successful insert grows the store by exactly one
   a_ins_grow: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && ins_ok) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow store");

   // A successful delete reports a position inside the store
   a_del_pos: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && del_ok) |-> (fin_pos < count_ff))
      else $error("delete position outside store");
`endif

endmodule

/* hdl/uvq_ctrl.sv */
// ----------------------------------------------------------------------------
// uvq_ctrl
// Sequencer: linear search of the store, then gap closing on delete.
// ----------------------------------------------------------------------------
module uvq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  uvq_pkg::sts_type sts,
   output uvq_pkg::cmd_type cmd
);
   import uvq_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SRCH_RD  = 6'b000010,
      S_SRCH_CMP = 6'b000100,
      S_SHFT_RD  = 6'b001000,
      S_SHFT_WR  = 6'b010000,
      S_FINISH   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            if (sts.at_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.srch_rd = 1'b1;
               state_in    = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (sts.match) begin
               cmd.set_found = 1'b1;
               state_in = (sts.mode == MODE_DELETE) ? S_SHFT_RD : S_FINISH;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_SHFT_RD: begin
            if (sts.next_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.shft_rd = 1'b1;
               state_in    = S_SHFT_WR;
            end
         end
         S_SHFT_WR: begin
            cmd.shft_wr = 1'b1;
            cmd.ptr_inc = 1'b1;
            state_in    = S_SHFT_RD;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule
